// ===== design/mpwc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the multichannel pulse width capture unit
// no dependencies

package mpwc_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_EDGE   = 2'd0;
  localparam logic [1:0] CMD_TRESET = 2'd1;
  localparam logic [1:0] CMD_LATCH  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_PULSE    = 2'd0;
  localparam logic [1:0] CFG_PULSE_GAIN   = 2'd1;
  localparam logic [1:0] CFG_MODE_CUTOFF  = 2'd2;
  localparam logic [1:0] CFG_MODE_CHANNEL = 2'd3;

  // configuration reset values
  localparam logic [15:0] MIN_PULSE_RST    = 16'd2000;
  localparam logic [15:0] PULSE_GAIN_RST   = 16'd8389;
  localparam logic [15:0] MODE_CUTOFF_RST  = 16'd3000;
  localparam logic [2:0]  MODE_CHANNEL_RST = 3'd0;

  // upper address bit of the channel memory: start times or captured widths
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_CAPT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_LMODE,
    ST_LDATA
  } mpwc_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic        pin_level;
    logic [15:0] timer_now;
    logic [15:0] reset_timer_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [15:0] pulse_width;
    logic [15:0] scaled_command;
    logic        mode_select;
    logic        last;
  } out_item_t;

endpackage

// ===== design/multichannel_pulse_width_capture_unit.sv =====
`timescale 1ns / 1ps
// top level of the multichannel pulse width capture unit
// depends on mpwc_pkg for item types, command codes and register indexes

// Pulse width capture for up to eight RC channels against a free-running
// 16-bit timer. Edge items (cmd 0) store a start time on a rising edge and
// a width on a falling edge, timer-reset items (cmd 1) note a timer wrap
// for all channels, and a latch item (cmd 2) publishes the captured widths
// and reports each channel that got a new width since the last latch, in
// ascending order, with a scaled command and the mode bit. Start times and
// captured widths live in one memory with one read and one write port and
// a registered read. A rising edge, a timer reset and an unused command
// complete without leaving idle; a falling edge reads the start time, then
// writes the width; a latch reads the mode channel width, then each reported
// channel in turn, one result per cycle as the single read port delivers
// widths while the output is not stalled. The input is stalled while an
// item is in progress. The memory needs no clearing pass: per-entry valid
// bits make unwritten entries read as zero right after reset.

module multichannel_pulse_width_capture_unit #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mpwc_pkg::in_item_t   in_data_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mpwc_pkg::out_item_t  out_data_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);
  import mpwc_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW    = CH_W + 1;
  localparam int DEPTH = 2 ** AW;

  // configuration registers
  logic [15:0] min_pulse_q, pulse_gain_q, mode_cutoff_q;
  logic [2:0]  mode_channel_q;

  // control state
  mpwc_state_e              state_q, state_d;
  logic [NUM_CHANNELS-1:0]  pending_q, reset_marks_q, pend_q;
  logic [15:0]              saved_reset_q;
  logic [CH_W-1:0]          edge_ch_q, cur_ch_q;
  logic [15:0]              now_q;
  logic                     mode_oob_q, mode_bit_q;

  // channel memory with its valid bits and read register
  logic [15:0]      mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [15:0]      rd_q;

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  // decoded input
  logic            in_fire, ch_ok, fire_rise, fire_fall, fire_treset, fire_latch;
  logic [CH_W-1:0] in_ch, mode_ch, nxt_ch;
  logic            mode_oob;

  // memory and output control
  logic          rd_en, wr_en, take_ch, out_load, slot_free;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0]   wr_data, fall_width, fall_add;

  // scaling
  logic [15:0] diff, scaled;
  logic [31:0] prod;

  assign in_ch   = in_data_i.channel[CH_W-1:0];
  assign mode_ch = mode_channel_q[CH_W-1:0];
  assign ch_ok   = int'(in_data_i.channel) < NUM_CHANNELS;
  assign mode_oob = int'(mode_channel_q) >= NUM_CHANNELS;

  // input taken only when no item is in progress
  assign in_stall_o = (state_q != ST_IDLE);

  assign in_fire     = in_valid_i && !in_stall_o;
  assign fire_rise   = in_fire && (in_data_i.cmd == CMD_EDGE) && ch_ok && in_data_i.pin_level;
  assign fire_fall   = in_fire && (in_data_i.cmd == CMD_EDGE) && ch_ok && !in_data_i.pin_level;
  assign fire_treset = in_fire && (in_data_i.cmd == CMD_TRESET);
  assign fire_latch  = in_fire && (in_data_i.cmd == CMD_LATCH);

  assign slot_free = !out_valid_q || !out_stall_i;

  // lowest channel still waiting to be reported
  always_comb begin
    nxt_ch = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        nxt_ch = CH_W'(i);
      end
    end
  end

  // falling edge width, wrapping mod 2^16, plus the pre-reset count if the timer wrapped
  assign fall_add   = reset_marks_q[edge_ch_q] ? saved_reset_q : 16'd0;
  assign fall_width = now_q - rd_q + fall_add;

  // Q0.16 command: ((width - min) * gain) >> 8, zero at or below min, saturated
  assign diff   = rd_q - min_pulse_q;
  assign prod   = {16'd0, diff} * {16'd0, pulse_gain_q};
  assign scaled = (rd_q <= min_pulse_q) ? 16'd0 :
                  (|prod[31:24])        ? 16'hFFFF : prod[23:8];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire_fall) begin
          state_d = ST_EDGE;
        end else if (fire_latch) begin
          state_d = ST_LMODE;
        end
      end
      ST_EDGE:  state_d = ST_IDLE;
      ST_LMODE: state_d = (pend_q == '0) ? ST_IDLE : ST_LDATA;
      ST_LDATA: begin
        if (slot_free && (pend_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    take_ch    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (fire_rise) begin
          wr_en   = 1'b1;
          wr_addr = {KIND_START, in_ch};
          wr_data = in_data_i.timer_now;
        end
        if (fire_fall) begin
          rd_en   = 1'b1;
          rd_addr = {KIND_START, in_ch};
        end
        if (fire_latch) begin
          rd_en   = 1'b1;
          rd_addr = {KIND_CAPT, mode_ch};
        end
      end
      ST_EDGE: begin
        wr_en   = 1'b1;
        wr_addr = {KIND_CAPT, edge_ch_q};
        wr_data = fall_width;
      end
      ST_LMODE: begin
        if (pend_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = {KIND_CAPT, nxt_ch};
          take_ch = 1'b1;
        end
      end
      ST_LDATA: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = {KIND_CAPT, nxt_ch};
            take_ch = 1'b1;
          end
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q    <= MIN_PULSE_RST;
      pulse_gain_q   <= PULSE_GAIN_RST;
      mode_cutoff_q  <= MODE_CUTOFF_RST;
      mode_channel_q <= MODE_CHANNEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_PULSE:    min_pulse_q    <= cfg_wdata_i;
        CFG_PULSE_GAIN:   pulse_gain_q   <= cfg_wdata_i;
        CFG_MODE_CUTOFF:  mode_cutoff_q  <= cfg_wdata_i;
        CFG_MODE_CHANNEL: mode_channel_q <= cfg_wdata_i[2:0];
        default:          min_pulse_q    <= min_pulse_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pending_q     <= '0;
      reset_marks_q <= '0;
      saved_reset_q <= '0;
      pend_q        <= '0;
      mode_oob_q    <= 1'b0;
      mode_bit_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire_rise) begin
        reset_marks_q[in_ch] <= 1'b0;
      end
      if (state_q == ST_EDGE) begin
        reset_marks_q[edge_ch_q] <= 1'b0;
        pending_q[edge_ch_q]     <= 1'b1;
      end
      if (fire_treset) begin
        reset_marks_q <= '1;
        saved_reset_q <= in_data_i.reset_timer_value;
      end
      if (fire_latch) begin
        pend_q     <= pending_q;
        pending_q  <= '0;
        mode_oob_q <= mode_oob;
      end
      if (take_ch) begin
        pend_q[nxt_ch] <= 1'b0;
      end
      // published mode width arrives in the cycle after the latch
      if (state_q == ST_LMODE) begin
        mode_bit_q <= !mode_oob_q && (rd_q > mode_cutoff_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire_fall) begin
      edge_ch_q <= in_ch;
      now_q     <= in_data_i.timer_now;
    end
    if (take_ch) begin
      cur_ch_q <= nxt_ch;
    end
    if (out_load) begin
      out_q.out_channel    <= 3'(cur_ch_q);
      out_q.pulse_width    <= rd_q;
      out_q.scaled_command <= scaled;
      out_q.mode_select    <= mode_bit_q;
      out_q.last           <= (pend_q == '0);
    end
  end

  // channel memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no read and write of the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("channel memory read and write collide");

  // the width write only follows an accepted falling edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE) |-> $past(fire_fall))
    else $error("width write without a falling edge");

  // pending marks are cleared when the latch is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LMODE) |-> (pending_q == '0))
    else $error("pending marks survive a latch");

  // only existing channels are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.out_channel) < NUM_CHANNELS))
    else $error("report for a channel out of range");

endmodule

// ===== dv/mpwc_checker.sv =====
`timescale 1ns / 1ps
// watches the item, report and register ports of the pulse width capture unit,
// predicts every report and compares it field by field; depends on mpwc_pkg

module mpwc_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  mpwc_pkg::in_item_t   in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  mpwc_pkg::out_item_t  out_data_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  output int                   fail_count_o,
  output int                   reports_left_o
);
  import mpwc_pkg::*;

  // register copies
  logic [15:0] min_pulse;
  logic [15:0] pulse_gain;
  logic [15:0] mode_cutoff;
  logic [2:0]  mode_channel;

  // per-channel capture state
  logic [15:0] start_time [8];
  logic [15:0] captured_width [8];
  logic [15:0] published_width [8];
  logic [7:0]  pending_marks;
  logic [7:0]  reset_marks;
  logic [15:0] saved_reset_value;

  out_item_t   due_reports [$];
  out_item_t   oldest_report;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // width to scaled command, Q8.8 gain, saturated
  function automatic logic [15:0] scaled_command(input logic [15:0] width);
    logic [15:0] span;
    logic [31:0] prod;
    if (width <= min_pulse) return '0;
    span = width - min_pulse;
    prod = ({16'd0, span} * {16'd0, pulse_gain}) >> 8;
    return (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
  endfunction

  // updates the capture state and queues the reports one item causes
  function automatic void capture_item(input in_item_t it);
    logic [7:0]  ch_bit;
    logic [15:0] width;
    logic        mode_bit;
    int          total;
    int          seen;
    out_item_t   rep;
    ch_bit = 8'd1 << it.channel;
    case (it.cmd)
      CMD_EDGE: begin
        if (it.pin_level) begin
          reset_marks = reset_marks & ~ch_bit;
          start_time[it.channel] = it.timer_now;
        end else begin
          width = it.timer_now - start_time[it.channel];
          if ((reset_marks & ch_bit) != '0) begin
            width = width + saved_reset_value;
            reset_marks = reset_marks & ~ch_bit;
          end
          captured_width[it.channel] = width;
          pending_marks = pending_marks | ch_bit;
        end
      end
      CMD_TRESET: begin
        reset_marks = '1;
        saved_reset_value = it.reset_timer_value;
      end
      CMD_LATCH: begin
        published_width = captured_width;
        mode_bit = published_width[mode_channel] > mode_cutoff;
        total = $countones(pending_marks);
        seen = 0;
        for (int i = 0; i < 8; i++) begin
          if (pending_marks[i]) begin
            seen++;
            rep.out_channel    = 3'(i);
            rep.pulse_width    = published_width[i];
            rep.scaled_command = scaled_command(published_width[i]);
            rep.mode_select    = mode_bit;
            rep.last           = (seen == total);
            due_reports.push_back(rep);
          end
        end
        pending_marks = '0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse = MIN_PULSE_RST;
      pulse_gain = PULSE_GAIN_RST;
      mode_cutoff = MODE_CUTOFF_RST;
      mode_channel = MODE_CHANNEL_RST;
      for (int i = 0; i < 8; i++) begin
        start_time[i] = '0;
        captured_width[i] = '0;
        published_width[i] = '0;
      end
      pending_marks = '0;
      reset_marks = '0;
      saved_reset_value = '0;
      due_reports.delete();
      reports_left_o <= 0;
    end else begin
      // a report leaving at this edge always belongs to an older latch
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          report_mismatch($sformatf("report for channel %0d with none expected",
                                    out_data_i.out_channel));
        end else begin
          oldest_report = due_reports.pop_front();
          check_field("out_channel", out_data_i.out_channel, oldest_report.out_channel);
          check_field("pulse_width", out_data_i.pulse_width, oldest_report.pulse_width);
          check_field("scaled_command", out_data_i.scaled_command,
                      oldest_report.scaled_command);
          check_field("mode_select", out_data_i.mode_select, oldest_report.mode_select);
          check_field("last", out_data_i.last, oldest_report.last);
        end
      end
      if (in_valid_i && !in_stall_i) capture_item(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_PULSE:    min_pulse = cfg_wdata_i;
          CFG_PULSE_GAIN:   pulse_gain = cfg_wdata_i;
          CFG_MODE_CUTOFF:  mode_cutoff = cfg_wdata_i;
          CFG_MODE_CHANNEL: mode_channel = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      reports_left_o <= due_reports.size();
    end
  end

endmodule

// ===== dv/tb_multichannel_pulse_width_capture_unit.sv =====
`timescale 1ns / 1ps
// top of the pulse width capture testbench: clock, reset, item stimulus,
// report stall, register writes and the verdict; depends on mpwc_pkg and mpwc_checker

module tb_multichannel_pulse_width_capture_unit;
  import mpwc_pkg::*;

  // cmd 3 has no name in the package, the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 288;
  localparam int SEGMENTS      = 6;
  localparam int HOLD_CYCLES   = 300;
  // a falling edge finishes in the cycle after it is taken, leave some slack
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_CYCLES  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  int          fail_count;
  int          reports_left;

  // sender and receiver idle rates in percent
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;

  // long receiver hold-off: the stimulus bumps the request count,
  // the receiver process counts the cycles itself
  int          hold_reqs = 0;
  int          hold_seen;
  int          hold_left;

  int          items_done = 0;
  int          cycle_count = 0;

  // free-running timer as the stimulus imagines it
  logic [15:0] sim_timer = '0;

  always #5 clk = ~clk;

  multichannel_pulse_width_capture_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mpwc_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .reports_left_o (reports_left)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [2:0] ch,
                                         input logic lvl, input logic [15:0] now,
                                         input logic [15:0] rval);
    in_item_t it;
    it.cmd = cmd;
    it.channel = ch;
    it.pin_level = lvl;
    it.timer_now = now;
    it.reset_timer_value = rval;
    return it;
  endfunction

  // offers one item, holding it until taken; valid stays high for the next item
  // unless the sender decides to idle first
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.cmd != CMD_UNUSED) items_done++;
  endtask

  // edge item, unused fields get random content
  task automatic send_edge(input int ch, input logic lvl, input logic [15:0] now);
    send_item(make_item(CMD_EDGE, 3'(ch), lvl, now, 16'($urandom)));
  endtask

  task automatic send_latch();
    send_item(make_item(CMD_LATCH, 3'($urandom), 1'($urandom), 16'($urandom),
                        16'($urandom)));
  endtask

  // timer reset item carrying the timer value just before the wrap
  task automatic send_timer_reset(input logic [15:0] rval);
    send_item(make_item(CMD_TRESET, 3'($urandom), 1'($urandom), 16'($urandom), rval));
  endtask

  // stop sending and wait until every report has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes of all four registers, block must be idle
  task automatic write_regs(input logic [15:0] min_p, input logic [15:0] gain,
                            input logic [15:0] cutoff, input logic [2:0] mode_ch);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MIN_PULSE;
    cfg_wdata <= min_p;
    @(posedge clk);
    cfg_idx <= CFG_PULSE_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_idx <= CFG_MODE_CUTOFF;
    cfg_wdata <= cutoff;
    @(posedge clk);
    cfg_idx <= CFG_MODE_CHANNEL;
    cfg_wdata <= {13'($urandom), mode_ch};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one RC frame: a pulse on each chosen channel, sometimes a timer wrap
  // inside a pulse, sometimes a lost falling edge, then usually a latch
  task automatic send_frame(input logic full);
    logic [7:0]  mask;
    logic [15:0] width;
    mask = full ? 8'hFF : 8'($urandom_range(255));
    for (int ch = 0; ch < 8; ch++) begin
      if (mask[ch]) begin
        // mostly servo-like widths, now and then anything at all
        width = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2400, 800));
        send_edge(ch, 1'b1, sim_timer);
        if ($urandom_range(5) == 0) begin
          send_timer_reset(sim_timer + 16'($urandom_range(width)));
          sim_timer = 16'($urandom_range(300));
        end
        sim_timer = sim_timer + width;
        if (full || $urandom_range(15) != 0) send_edge(ch, 1'b0, sim_timer);
        sim_timer = sim_timer + 16'($urandom_range(400));
      end
    end
    if (full || $urandom_range(7) != 0) send_latch();
  endtask

  // anything the fields allow, including the unused command
  task automatic send_noise();
    send_item(make_item(2'($urandom_range(3)), 3'($urandom), 1'($urandom),
                        16'($urandom), 16'($urandom)));
  endtask

  initial begin
    int seg_start;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, registers at their reset values
    send_latch();                               // latch with nothing pending
    send_edge(3, 1'b0, 16'hFFFF);               // falling edge with no rising edge
    send_item(make_item(CMD_UNUSED, 3'($urandom), 1'($urandom), 16'($urandom),
                        16'($urandom)));
    send_edge(0, 1'b1, 16'hFFFF);               // width across the timer wrap
    send_edge(0, 1'b0, 16'd1999);
    send_edge(7, 1'b1, 16'd100);                // timer reset inside a pulse
    send_timer_reset(16'hFFFF);
    send_edge(7, 1'b0, 16'd50);
    send_edge(5, 1'b1, 16'd10);                 // rising edge clears the reset mark
    send_timer_reset(16'd500);
    send_edge(5, 1'b1, 16'd20);
    send_edge(5, 1'b0, 16'd3020);
    send_edge(1, 1'b0, 16'd2000);               // width equal to min pulse
    send_edge(2, 1'b1, 16'd0);                  // just above min pulse
    send_edge(2, 1'b0, 16'd2001);
    send_edge(6, 1'b1, 16'd0);                  // zero width
    send_edge(6, 1'b0, 16'd0);
    send_latch();                               // seven reports
    send_latch();                               // nothing new since last latch
    send_edge(0, 1'b1, 16'd5000);               // mode channel just above cutoff
    send_edge(0, 1'b0, 16'd8001);
    send_latch();
    settle();

    // random part: two segments per idle profile, a register setting each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: write_regs(16'd0, 16'hFFFF, 16'd0, 3'd7);
        1: write_regs(16'hFFFF, 16'd0, 16'hFFFF, 3'd0);
        default: write_regs(16'($urandom_range(2500, 500)),
                            16'(24'hFF_FFFF / $urandom_range(1500, 500)),
                            16'($urandom_range(4000)), 3'($urandom_range(7)));
      endcase
      case (seg / 2)
        0: begin src_idle_pct = 7;  snk_idle_pct = 61; end
        1: begin src_idle_pct = 61; snk_idle_pct = 7;  end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase

      seg_start = items_done;

      // receiver holds off while full frames pile up behind the output
      if (seg == 0 || seg == 4) begin
        hold_reqs <= hold_reqs + 1;
        send_frame(1'b1);
        send_frame(1'b1);
      end

      while (items_done < seg_start + RANDOM_ITEMS / SEGMENTS) begin
        if ($urandom_range(99) < 80) send_frame(1'b0);
        else send_noise();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
